>>> rtl/alpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package alpe_pkg;

  // Field widths
  localparam int unsigned OP_W       = 2;
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned PIXEL_W    = 3 * LEVEL_W;
  localparam int unsigned DUTY_W     = 16;
  localparam int unsigned LATCH_W    = 8;
  localparam int unsigned LED_CNT_W  = 6;
  localparam int unsigned BIT_POS_W  = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned S_DATA_W   = 32;
  localparam int unsigned M_DATA_W   = 16;

  // Entries the pixel index field can reach
  localparam int unsigned IDX_SPAN = 1 << IDX_W;

  // Default parameters
  localparam int unsigned MAX_LEDS_DEF     = 32;
  localparam int unsigned BITS_PER_LED_DEF = 24;
  localparam int unsigned QUEUE_DEPTH      = 2;

  // Register reset values
  localparam logic [DUTY_W-1:0]    ONE_DUTY_RST    = DUTY_W'(40);
  localparam logic [DUTY_W-1:0]    ZERO_DUTY_RST   = DUTY_W'(20);
  localparam logic [LATCH_W-1:0]   LATCH_COUNT_RST = LATCH_W'(50);
  localparam logic [LED_CNT_W-1:0] LED_COUNT_RST   = LED_CNT_W'(24);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ONE_DUTY    = 2'd0,
    CFG_ZERO_DUTY   = 2'd1,
    CFG_LATCH_COUNT = 2'd2,
    CFG_LED_COUNT   = 2'd3
  } cfg_e;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_START,
    CMD_TICK
  } cmd_e;

  // Decoded request handed from front to back
  typedef struct packed {
    cmd_e               kind;
    logic [IDX_W-1:0]   idx;
    logic [PIXEL_W-1:0] pixel;  // green:red:blue
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/alpe_front.sv
`timescale 1ns / 1ps
`default_nettype none

module alpe_front (
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [alpe_pkg::S_DATA_W-1:0]        s_axis_tdata,
  input  wire logic [alpe_pkg::OP_W-1:0]            s_axis_tuser,
  input  wire logic                                 q_full_i,
  output logic                                      q_push_o,
  output alpe_pkg::cmd_t                            q_cmd_o
);

  logic accept;

  assign s_axis_tready = !q_full_i;
  assign accept        = s_axis_tvalid && !q_full_i;

  // tdata: [4:0] index, [12:5] red, [20:13] green, [28:21] blue
  always_comb begin
    q_push_o      = 1'b0;
    q_cmd_o.kind  = alpe_pkg::CMD_TICK;
    q_cmd_o.idx   = s_axis_tdata[4:0];
    q_cmd_o.pixel = {s_axis_tdata[20:13], s_axis_tdata[12:5], s_axis_tdata[28:21]};
    case (alpe_pkg::op_e'(s_axis_tuser))
      alpe_pkg::OP_WRITE: begin
        q_push_o     = accept;
        q_cmd_o.kind = alpe_pkg::CMD_WRITE;
      end
      alpe_pkg::OP_START: begin
        q_push_o     = accept;
        q_cmd_o.kind = alpe_pkg::CMD_START;
      end
      alpe_pkg::OP_TICK: begin
        q_push_o     = accept;
        q_cmd_o.kind = alpe_pkg::CMD_TICK;
      end
      default: begin
        // unused opcode: taken and dropped
        q_push_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/alpe_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module alpe_queue #(
  parameter int unsigned DEPTH = alpe_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire alpe_pkg::cmd_t push_cmd_i,
  output logic                full_o,
  output logic                valid_o,
  output alpe_pkg::cmd_t      head_o,
  input  wire logic           pop_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  alpe_pkg::cmd_t   entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/alpe_back.sv
`timescale 1ns / 1ps
`default_nettype none

module alpe_back #(
  parameter int unsigned MAX_LEDS     = alpe_pkg::MAX_LEDS_DEF,
  parameter int unsigned BITS_PER_LED = alpe_pkg::BITS_PER_LED_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cmd_valid_i,
  input  wire alpe_pkg::cmd_t                        cmd_i,
  output logic                                       cmd_pop_o,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [alpe_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [alpe_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  output logic [alpe_pkg::M_DATA_W-1:0]              m_axis_tdata,
  output logic                                       m_axis_tuser,
  output logic                                       m_axis_tlast
);

  // Indexes above the pixel index field's span are never written and read as zero
  localparam int unsigned STORE_DEPTH = (MAX_LEDS < alpe_pkg::IDX_SPAN) ?
                                        MAX_LEDS : alpe_pkg::IDX_SPAN;
  localparam int unsigned SIDX_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned POS_W       = alpe_pkg::LED_CNT_W;
  localparam int unsigned BP_W        = alpe_pkg::BIT_POS_W;

  logic [alpe_pkg::PIXEL_W-1:0]   store_q [STORE_DEPTH];
  logic [alpe_pkg::DUTY_W-1:0]    one_duty_q, zero_duty_q;
  logic [alpe_pkg::LATCH_W-1:0]   latch_cnt_q;
  logic [alpe_pkg::LED_CNT_W-1:0] led_cnt_q;

  logic                           active_q, active_d;
  logic [POS_W-1:0]               pos_q, pos_d;
  logic [BP_W-1:0]                bit_pos_q, bit_pos_d;
  logic [alpe_pkg::LATCH_W-1:0]   gap_cnt_q, gap_cnt_d;

  logic                           out_valid_q, out_valid_d;
  logic [alpe_pkg::DUTY_W-1:0]    out_duty_q, out_duty_d;
  logic                           out_gap_q, out_gap_d;
  logic                           out_last_q, out_last_d;

  logic [POS_W-1:0]               n_leds;
  logic [alpe_pkg::PIXEL_W-1:0]   rd_word;
  logic [31:0]                    rd_word32;
  logic [BP_W-1:0]                shift;
  logic                           data_bit;
  logic                           out_free;
  logic                           is_result;
  logic                           res_push;
  logic                           store_we;
  logic                           cfg_we;

  assign n_leds    = (32'(led_cnt_q) > MAX_LEDS) ? POS_W'(MAX_LEDS) : led_cnt_q;
  assign rd_word   = (32'(pos_q) < STORE_DEPTH) ? store_q[pos_q[SIDX_W-1:0]] : '0;
  assign rd_word32 = {{(32 - alpe_pkg::PIXEL_W){1'b0}}, rd_word};
  assign shift     = BP_W'(BITS_PER_LED - 1) - bit_pos_q;
  assign data_bit  = rd_word32[shift];

  assign out_free  = !out_valid_q || m_axis_tready;
  assign is_result = cmd_valid_i && (cmd_i.kind == alpe_pkg::CMD_TICK) && active_q;
  assign cmd_pop_o = cmd_valid_i && (!is_result || out_free);
  assign res_push  = cmd_pop_o && is_result;
  assign store_we  = cmd_pop_o && (cmd_i.kind == alpe_pkg::CMD_WRITE) && !active_q &&
                     (POS_W'(cmd_i.idx) < n_leds);

  always_comb begin
    active_d    = active_q;
    pos_d       = pos_q;
    bit_pos_d   = bit_pos_q;
    gap_cnt_d   = gap_cnt_q;
    out_duty_d  = out_duty_q;
    out_gap_d   = out_gap_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    if (cmd_pop_o) begin
      case (cmd_i.kind)
        alpe_pkg::CMD_START: begin
          if (!active_q && (n_leds != '0 || latch_cnt_q != '0)) begin
            active_d  = 1'b1;
            pos_d     = '0;
            bit_pos_d = '0;
            gap_cnt_d = '0;
          end
        end
        alpe_pkg::CMD_TICK: begin
          if (active_q) begin
            out_valid_d = 1'b1;
            out_last_d  = 1'b0;
            if (pos_q < n_leds) begin
              out_duty_d = data_bit ? one_duty_q : zero_duty_q;
              out_gap_d  = 1'b0;
              if (bit_pos_q == BP_W'(BITS_PER_LED - 1)) begin
                bit_pos_d  = '0;
                pos_d      = pos_q + 1'b1;
                out_last_d = (pos_q + 1'b1 >= n_leds) && (latch_cnt_q == '0);
              end else begin
                bit_pos_d = bit_pos_q + 1'b1;
              end
            end else begin
              out_duty_d = '0;
              out_gap_d  = 1'b1;
              if (gap_cnt_q < latch_cnt_q) begin
                gap_cnt_d  = gap_cnt_q + 1'b1;
                out_last_d = (gap_cnt_q + 1'b1 >= latch_cnt_q);
              end else begin
                out_last_d = 1'b1;
              end
            end
            if (out_last_d) begin
              active_d = 1'b0;
            end
          end
        end
        default: begin
          // pixel writes are handled by store_we
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      pos_q       <= '0;
      bit_pos_q   <= '0;
      gap_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      pos_q       <= pos_d;
      bit_pos_q   <= bit_pos_d;
      gap_cnt_q   <= gap_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_duty_q <= out_duty_d;
    out_gap_q  <= out_gap_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store_q[i] <= '0;
      end
    end else if (store_we) begin
      store_q[cmd_i.idx[SIDX_W-1:0]] <= cmd_i.pixel;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_duty_q  <= alpe_pkg::ONE_DUTY_RST;
      zero_duty_q <= alpe_pkg::ZERO_DUTY_RST;
      latch_cnt_q <= alpe_pkg::LATCH_COUNT_RST;
      led_cnt_q   <= alpe_pkg::LED_COUNT_RST;
    end else if (cfg_we) begin
      case (alpe_pkg::cfg_e'(cfg_index_i))
        alpe_pkg::CFG_ONE_DUTY:    one_duty_q  <= cfg_data_i;
        alpe_pkg::CFG_ZERO_DUTY:   zero_duty_q <= cfg_data_i;
        alpe_pkg::CFG_LATCH_COUNT: latch_cnt_q <= cfg_data_i[alpe_pkg::LATCH_W-1:0];
        alpe_pkg::CFG_LED_COUNT:   led_cnt_q   <= cfg_data_i[alpe_pkg::LED_CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_duty_q;
  assign m_axis_tuser  = out_gap_q;
  assign m_axis_tlast  = out_last_q;

  a_result_needs_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> active_q)
    else $error("result produced outside a frame");

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && out_last_d) |=> !active_q)
    else $error("frame still active after its last pulse");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> out_free)
    else $error("pending result overwritten");

  a_bit_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (32'(bit_pos_q) < BITS_PER_LED))
    else $error("bit position out of range");

  a_no_write_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_we |-> !active_q)
    else $error("pixel store written during a frame");

endmodule

`default_nettype wire

>>> rtl/addressable_led_pulse_encoder_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Pulse encoder for a chain of addressable RGB LEDs.
// s_axis carries requests: tuser is the opcode (write pixel, start frame,
// pulse tick), tdata the pixel index and levels. m_axis gives one PWM
// compare value per tick while a frame runs: tdata is the duty, tuser marks
// a reset pulse of the trailing gap, tlast the last pulse of the frame.
// Pixels go out green, red, blue, MSB first, then latch_pulse_count zeros.
// The cfg channel writes the four registers; it is always ready and is to
// be used only while no request is in flight.
// Throughput is one request per cycle while m_axis is not stalled. A tick
// accepted on s_axis is written into a two-entry request queue that feeds
// the executing side, which updates the frame counters and reads the pixel
// store in the same cycle, then loads the output register that drives m_axis.
// When m_axis stalls, requests keep draining in order until a tick of a running
// frame reaches the head of the queue; it holds there, and s_axis_tready drops
// once the queue is full.
// Reset clears the pixel store, ends any frame and restores the register
// defaults; no clearing pass is needed.

module addressable_led_pulse_encoder_core #(
  parameter int unsigned MAX_LEDS     = alpe_pkg::MAX_LEDS_DEF,
  parameter int unsigned BITS_PER_LED = alpe_pkg::BITS_PER_LED_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [4:0] pixel_index, [12:5] red_level, [20:13] green_level,
  // [28:21] blue_level, [31:29] zero
  input  wire logic [alpe_pkg::S_DATA_W-1:0]     s_axis_tdata,
  // [1:0] opcode
  input  wire logic [alpe_pkg::OP_W-1:0]         s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [15:0] pulse_duty
  output logic [alpe_pkg::M_DATA_W-1:0]          m_axis_tdata,
  // [0] in_latch_gap
  output logic                                   m_axis_tuser,
  output logic                                   m_axis_tlast,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [alpe_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [alpe_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic           q_push, q_full, q_valid, q_pop;
  alpe_pkg::cmd_t q_in, q_head;

  alpe_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_cmd_o       (q_in)
  );

  alpe_queue #(
    .DEPTH (alpe_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_in),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (q_head),
    .pop_i      (q_pop)
  );

  alpe_back #(
    .MAX_LEDS     (MAX_LEDS),
    .BITS_PER_LED (BITS_PER_LED)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_i         (q_head),
    .cmd_pop_o     (q_pop),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned OP_W         = alpe_pkg::OP_W;
  localparam int unsigned IDX_W        = alpe_pkg::IDX_W;
  localparam int unsigned LEVEL_W      = alpe_pkg::LEVEL_W;
  localparam int unsigned PIXEL_W      = alpe_pkg::PIXEL_W;
  localparam int unsigned DUTY_W       = alpe_pkg::DUTY_W;
  localparam int unsigned LATCH_W      = alpe_pkg::LATCH_W;
  localparam int unsigned LED_CNT_W    = alpe_pkg::LED_CNT_W;
  localparam int unsigned CFG_IDX_W    = alpe_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W   = alpe_pkg::CFG_DATA_W;
  localparam int unsigned S_DATA_W     = alpe_pkg::S_DATA_W;
  localparam int unsigned M_DATA_W     = alpe_pkg::M_DATA_W;
  localparam int unsigned MAX_LEDS     = alpe_pkg::MAX_LEDS_DEF;
  localparam int unsigned LED_BITS     = alpe_pkg::BITS_PER_LED_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS = 300;

  typedef struct {
    logic [OP_W-1:0]    opcode;
    logic [IDX_W-1:0]   idx;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } led_req_t;

  typedef struct {
    logic [DUTY_W-1:0] duty;
    logic              gap;
    logic              last;
  } pulse_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata = '0;
  logic [OP_W-1:0]       s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  addressable_led_pulse_encoder_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Shadow of the encoder: pixel store, frame counters, registers
  logic [PIXEL_W-1:0]   led_mem [MAX_LEDS];
  bit                   frame_on = 1'b0;
  int unsigned          led_pos = 0;
  int unsigned          bit_pos = 0;
  int unsigned          gap_cnt = 0;
  logic [DUTY_W-1:0]    one_duty_r = alpe_pkg::ONE_DUTY_RST;
  logic [DUTY_W-1:0]    zero_duty_r = alpe_pkg::ZERO_DUTY_RST;
  logic [LATCH_W-1:0]   latch_r = alpe_pkg::LATCH_COUNT_RST;
  logic [LED_CNT_W-1:0] leds_r = alpe_pkg::LED_COUNT_RST;

  led_req_t    req_backlog[$];
  pulse_t      pulses_due[$];
  led_req_t    cur_req;
  int unsigned src_idle_pct = 38;
  int unsigned snk_idle_pct = 58;
  int unsigned sink_hold_left = 0;
  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned n_pulses = 0;
  int unsigned n_frames = 0;
  int unsigned n_cfg = 0;
  int unsigned n_fail = 0;

  initial begin
    foreach (led_mem[i]) led_mem[i] = '0;
  end

  function automatic int unsigned leds_sent();
    return (leds_r > MAX_LEDS) ? MAX_LEDS : int'(leds_r);
  endfunction

  // Apply one accepted request; a tick in a running frame yields one pulse
  task automatic encode_request(input led_req_t r);
    int unsigned n;
    int unsigned sh;
    pulse_t      p;
    logic        bitv;
    n = leds_sent();
    case (r.opcode)
      alpe_pkg::OP_WRITE: begin
        if (!frame_on && r.idx < n) led_mem[r.idx] = {r.green, r.red, r.blue};
      end
      alpe_pkg::OP_START: begin
        if (!frame_on && (n > 0 || latch_r > 0)) begin
          frame_on = 1'b1;
          led_pos  = 0;
          bit_pos  = 0;
          gap_cnt  = 0;
          n_frames++;
        end
      end
      alpe_pkg::OP_TICK: begin
        if (frame_on) begin
          p.last = 1'b0;
          if (led_pos < n) begin
            sh   = LED_BITS - 1 - bit_pos;
            bitv = (sh < PIXEL_W) ? led_mem[led_pos][sh] : 1'b0;
            p.duty = bitv ? one_duty_r : zero_duty_r;
            p.gap  = 1'b0;
            bit_pos++;
            if (bit_pos >= LED_BITS) begin
              bit_pos = 0;
              led_pos++;
              if (led_pos >= n && latch_r == 0) p.last = 1'b1;
            end
          end else begin
            p.duty = '0;
            p.gap  = 1'b1;
            if (gap_cnt < latch_r) begin
              gap_cnt++;
              if (gap_cnt >= latch_r) p.last = 1'b1;
            end else begin
              // gap already complete: a single closing pulse
              p.last = 1'b1;
            end
          end
          if (p.last) frame_on = 1'b0;
          pulses_due.push_back(p);
        end
      end
      default: ;
    endcase
  endtask

  // Request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        encode_request(cur_req);
        n_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_req = req_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {3'b000, cur_req.blue, cur_req.green, cur_req.red, cur_req.idx};
          s_axis_tuser  <= cur_req.opcode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Pulse receiver, with an optional long hold-off
  always @(posedge clk_i) begin
    if (sink_hold_left != 0) begin
      m_axis_tready <= 1'b0;
      sink_hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic note_failure(input string what, input pulse_t want);
    n_fail++;
    if (n_fail <= 10)
      $display("%t ERROR %s: exp duty=%h gap=%b last=%b, got duty=%h gap=%b last=%b",
               $realtime, what, want.duty, want.gap, want.last,
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
  endtask

  // Pulse monitor
  always @(posedge clk_i) begin
    pulse_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_pulses++;
      if (pulses_due.size() == 0) begin
        want = '{duty: 'x, gap: 1'bx, last: 1'bx};
        note_failure("pulse with nothing pending", want);
      end else begin
        want = pulses_due.pop_front();
        if (m_axis_tdata !== want.duty || m_axis_tuser !== want.gap ||
            m_axis_tlast !== want.last)
          note_failure("pulse mismatch", want);
      end
    end
  end

  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return LEVEL_W'($urandom_range(255));
    endcase
  endfunction

  function automatic led_req_t mk_req(input logic [OP_W-1:0] op, input int unsigned idx,
                                      input logic [LEVEL_W-1:0] red,
                                      input logic [LEVEL_W-1:0] green,
                                      input logic [LEVEL_W-1:0] blue);
    led_req_t r;
    r.opcode = op;
    r.idx    = IDX_W'(idx);
    r.red    = red;
    r.green  = green;
    r.blue   = blue;
    return r;
  endfunction

  function automatic led_req_t any_req(input logic [OP_W-1:0] op);
    return mk_req(op, $urandom_range(alpe_pkg::IDX_SPAN - 1), pick_level(), pick_level(),
                  pick_level());
  endfunction

  task automatic push_req(input led_req_t r);
    req_backlog.push_back(r);
    n_queued++;
  endtask

  // Writes, a start, enough ticks to finish the frame, stray requests mixed in
  task automatic queue_frame(input int unsigned n_writes, input bit noisy);
    int unsigned n;
    int unsigned ticks;
    int unsigned idx;
    led_req_t    r;
    n     = leds_sent();
    ticks = n * LED_BITS + latch_r;
    repeat (n_writes) begin
      idx = (n > 0 && $urandom_range(3) != 0) ? $urandom_range(n - 1) : $urandom_range(31);
      r = any_req(alpe_pkg::OP_WRITE);
      r.idx = IDX_W'(idx);
      push_req(r);
    end
    if (noisy && $urandom_range(2) == 0)
      push_req(any_req($urandom_range(1) ? alpe_pkg::OP_TICK : OP_UNUSED));
    push_req(any_req(alpe_pkg::OP_START));
    for (int unsigned i = 0; i < ticks; i++) begin
      // ticks are kept out of the noise so the frame ends where counted
      if (noisy && $urandom_range(9) == 0) begin
        case ($urandom_range(2))
          0:       push_req(any_req(alpe_pkg::OP_WRITE));
          1:       push_req(any_req(alpe_pkg::OP_START));
          default: push_req(any_req(OP_UNUSED));
        endcase
      end
      push_req(any_req(alpe_pkg::OP_TICK));
    end
    if (noisy && $urandom_range(1) == 0) push_req(any_req(alpe_pkg::OP_TICK));
  endtask

  // Caller sits just after a rising edge; valid stays up until the batch ends
  task automatic cfg_put(input alpe_pkg::cfg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      alpe_pkg::CFG_ONE_DUTY:    one_duty_r  = data;
      alpe_pkg::CFG_ZERO_DUTY:   zero_duty_r = data;
      alpe_pkg::CFG_LATCH_COUNT: latch_r     = data[LATCH_W-1:0];
      alpe_pkg::CFG_LED_COUNT:   leds_r      = data[LED_CNT_W-1:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic cfg_set(input logic [DUTY_W-1:0] one_d, input logic [DUTY_W-1:0] zero_d,
                         input logic [LATCH_W-1:0] latch, input logic [LED_CNT_W-1:0] leds);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    cfg_put(alpe_pkg::CFG_ONE_DUTY, one_d);
    cfg_put(alpe_pkg::CFG_ZERO_DUTY, zero_d);
    // bits above the register width must be dropped
    cfg_put(alpe_pkg::CFG_LATCH_COUNT, {junk[CFG_DATA_W-1:LATCH_W], latch});
    cfg_put(alpe_pkg::CFG_LED_COUNT, {junk[CFG_DATA_W-1:LED_CNT_W], leds});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_quiet();
    do @(posedge clk_i);
    while (req_backlog.size() != 0 || s_axis_tvalid || pulses_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [DUTY_W-1:0] pick_duty();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return DUTY_W'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned rand_base;
    int unsigned leds;
    int unsigned latch;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset count of 24: index 23 lands, index 24 is dropped
    push_req(mk_req(alpe_pkg::OP_WRITE, 23, 8'hFF, 8'h0F, 8'hA5));
    push_req(mk_req(alpe_pkg::OP_WRITE, 24, 8'hFF, 8'hFF, 8'hFF));
    wait_quiet();

    // Count above the store size, default duties and gap of 50
    cfg_put(alpe_pkg::CFG_LED_COUNT, 16'd63);
    cfg_valid_i <= 1'b0;
    queue_frame(12, 1'b1);
    wait_quiet();

    // Single LED, no gap: the last data pulse closes the frame
    cfg_set('1, '0, 8'd0, 6'd1);
    push_req(any_req(alpe_pkg::OP_TICK));                             // tick with no frame
    push_req(any_req(OP_UNUSED));
    push_req(mk_req(alpe_pkg::OP_WRITE, 1, 8'hFF, 8'hFF, 8'hFF));     // out of range
    push_req(mk_req(alpe_pkg::OP_WRITE, 31, 8'hFF, 8'hFF, 8'hFF));
    push_req(mk_req(alpe_pkg::OP_WRITE, 0, 8'hFF, 8'h81, 8'h00));
    push_req(mk_req(alpe_pkg::OP_START, 0, '0, '0, '0));
    push_req(mk_req(alpe_pkg::OP_WRITE, 0, 8'h00, 8'h00, 8'h00));     // ignored mid-frame
    push_req(mk_req(alpe_pkg::OP_START, 0, '0, '0, '0));              // ignored mid-frame
    repeat (LED_BITS + 1) push_req(any_req(alpe_pkg::OP_TICK));
    wait_quiet();

    // Empty frame: nothing to send, start does nothing
    cfg_set('1, '0, 8'd0, 6'd0);
    push_req(any_req(alpe_pkg::OP_START));
    push_req(any_req(alpe_pkg::OP_TICK));
    wait_quiet();

    // No pixels, one gap pulse
    cfg_set(16'h1234, 16'h8001, 8'd1, 6'd0);
    push_req(any_req(alpe_pkg::OP_START));
    push_req(any_req(alpe_pkg::OP_TICK));
    push_req(any_req(alpe_pkg::OP_TICK));
    wait_quiet();

    // Longest gap with no pixels, output held off so the input stalls
    cfg_set('0, '1, 8'd255, 6'd0);
    queue_frame(0, 1'b0);
    sink_hold_left = 400;
    wait_quiet();

    rand_base = n_queued;
    while (n_queued - rand_base < RANDOM_ITEMS) begin
      if (n_queued - rand_base >= 2 * RANDOM_ITEMS / 3) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end else if (n_queued - rand_base >= RANDOM_ITEMS / 3) begin
        src_idle_pct = 58;
        snk_idle_pct = 38;
      end
      case ($urandom_range(11))
        0:       leds = 0;
        1, 2:    leds = $urandom_range(4, 8);
        default: leds = $urandom_range(1, 3);
      endcase
      case ($urandom_range(6))
        0:       latch = 0;
        default: latch = $urandom_range(1, 8);
      endcase
      cfg_set(pick_duty(), pick_duty(), LATCH_W'(latch), LED_CNT_W'(leds));
      queue_frame($urandom_range(leds + 2), $urandom_range(3) != 0);
      wait_quiet();
    end

    wait_quiet();
    $display("Covered %0d requests, %0d pulses, %0d frames, %0d register writes",
             n_accepted, n_pulses, n_frames, n_cfg);
    $display("LED counts 0 to 63, gap lengths 0 to 255, duty codes 0 and 0xFFFF; %0d errors",
             n_fail);
    if (n_fail == 0) begin
      $display("addressable_led_pulse_encoder_core test passed");
    end else begin
      $display("addressable_led_pulse_encoder_core test failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Timeout with %0d requests queued and %0d pulses pending",
             req_backlog.size(), pulses_due.size());
    $display("addressable_led_pulse_encoder_core test failed");
    $finish;
  end

endmodule

>>> files.f
rtl/alpe_pkg.sv
rtl/alpe_front.sv
rtl/alpe_queue.sv
rtl/alpe_back.sv
rtl/addressable_led_pulse_encoder_core.sv
dv/tb_top.sv
